/* rtl/wcr_pkg.sv */
// Shared constants and types for the weighted centroid recenter block.
package wcr_pkg;

  // Point weights are unsigned Q0.16
  localparam int unsigned WEIGHT_BITS = 16;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_DRAIN = 5'b00010,
    S_SETUP = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } wcr_state_e;

endpackage

/* rtl/wcr_if.sv */
// Point input and recentered result channel interfaces.
interface wcr_in_if
  import wcr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  coord_x;
  logic signed [COORD_BITS-1:0]  coord_y;
  logic        [WEIGHT_BITS-1:0] point_weight;
  logic                          point_valid;
  logic                          last_point;

  modport source (
    output valid, coord_x, coord_y, point_weight, point_valid, last_point,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, point_weight, point_valid, last_point,
    output ready
  );
endinterface

interface wcr_out_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS:0]   adj_x;
  logic signed [COORD_BITS:0]   adj_y;
  logic                         point_ok;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic                         center_ok;
  logic                         last_out;

  modport source (
    output valid, adj_x, adj_y, point_ok, center_x, center_y, center_ok, last_out,
    input  ready
  );
  modport sink (
    input  valid, adj_x, adj_y, point_ok, center_x, center_y, center_ok, last_out,
    output ready
  );
endinterface

/* rtl/weighted_centroid_recenter_unit.sv */
// Weighted centroid of a point set, then every stored valid point shifted by minus it if the weight sum is nonzero.
//
// Points enter on pts_i, one transfer per cycle while the block is loading.
// Each point is written to an on-chip point memory and, when valid, its
// weighted coordinates are added to running sums (multiply stage, then
// accumulate). Points beyond MAX_POINTS are dropped. The transfer marked
// last_point closes the set: a drain state, a setup state, then a
// restoring divider that takes one quotient bit per cycle for x and y in
// parallel, skipped when the weight sum is zero. Results then leave on
// res_o in arrival order; a new memory read is not issued while the
// previous one is pending. pts_i.ready is low from the last point until
// the final result of the pass has been transferred. A stalled receiver
// holds the output register and the memory reads wait behind it; nothing
// is lost. Reset clears the sums, the count and the sequencer; the point
// memory is not cleared, since only entries of the current set are ever
// read.
module weighted_centroid_recenter_unit
  import wcr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wcr_in_if.sink     pts_i,
  wcr_out_if.source  res_o
);

  localparam int unsigned LOG_PTS   = $clog2(MAX_POINTS);
  localparam int unsigned SW_BITS   = WEIGHT_BITS + LOG_PTS;
  localparam int unsigned PROD_BITS = COORD_BITS + WEIGHT_BITS;
  localparam int unsigned SUM_BITS  = PROD_BITS + LOG_PTS;
  localparam int unsigned CNT_BITS  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_BITS  = (MAX_POINTS > 1) ? LOG_PTS : 1;
  localparam int unsigned DC_BITS   = $clog2(SUM_BITS);
  localparam int unsigned MEM_W     = 2 * COORD_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(MAX_POINTS);
  localparam logic [DC_BITS-1:0]  DIV_LAST = DC_BITS'(SUM_BITS - 1);

  wcr_state_e state_q, state_d;

  logic                 in_xfer, out_xfer, store_en, last_xfer;
  logic [CNT_BITS-1:0]  cnt_q, rd_cnt_q;

  // Multiply stage
  logic signed [PROD_BITS:0]   prod_x_full, prod_y_full;
  logic signed [PROD_BITS-1:0] prod_wx_q, prod_wy_q;
  logic [WEIGHT_BITS-1:0]      prod_w_q;
  logic                        prod_vld_q;

  // Running sums
  logic signed [SUM_BITS-1:0] sum_wx_q, sum_wy_q;
  logic [SW_BITS-1:0]         sum_w_q;

  // Divider
  logic [SUM_BITS-1:0]   dvd_x_q, dvd_y_q;
  logic [SW_BITS-1:0]    rem_x_q, rem_y_q, rem_x_nx, rem_y_nx;
  logic [COORD_BITS-1:0] quo_x_q, quo_y_q, quo_x_nx, quo_y_nx;
  logic [SW_BITS:0]      trial_x, trial_y;
  logic                  ge_x, ge_y, neg_x_q, neg_y_q;
  logic [DC_BITS-1:0]    div_cnt_q;

  // Centroid
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic                         cok_q;

  // Point memory and read path
  logic [MEM_W-1:0] mem_q [MAX_POINTS];
  logic [MEM_W-1:0] rdata_q;
  logic             rd_pend_q, rd_issue;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic             rd_valid, rd_ok;

  // Output register
  logic                         out_vld_q;
  logic signed [COORD_BITS:0]   adj_x_q, adj_y_q;
  logic                         pok_q, last_q;

  assign pts_i.ready = (state_q == S_LOAD);
  assign in_xfer     = pts_i.valid && pts_i.ready;
  assign store_en    = in_xfer && (cnt_q < CNT_MAX);
  assign out_xfer    = out_vld_q && res_o.ready;
  assign last_xfer   = out_xfer && last_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:  if (in_xfer && pts_i.last_point) state_d = S_DRAIN;
      S_DRAIN: state_d = S_SETUP;
      S_SETUP: state_d = (sum_w_q == '0) ? S_EMIT : S_DIV;
      S_DIV:   if (div_cnt_q == DIV_LAST) state_d = S_EMIT;
      S_EMIT:  if (last_xfer) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (last_xfer) begin
      cnt_q <= '0;
    end else if (store_en) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Weighted products, registered in the stage before the sums
  assign prod_x_full = $signed({1'b0, pts_i.point_weight}) * pts_i.coord_x;
  assign prod_y_full = $signed({1'b0, pts_i.point_weight}) * pts_i.coord_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= store_en && pts_i.point_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      prod_wx_q <= prod_x_full[PROD_BITS-1:0];
      prod_wy_q <= prod_y_full[PROD_BITS-1:0];
      prod_w_q  <= pts_i.point_weight;
    end
  end

  // Accumulate; clear once the pass has gone out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_wx_q <= '0;
      sum_wy_q <= '0;
      sum_w_q  <= '0;
    end else if (last_xfer) begin
      sum_wx_q <= '0;
      sum_wy_q <= '0;
      sum_w_q  <= '0;
    end else if (prod_vld_q) begin
      sum_wx_q <= sum_wx_q + SUM_BITS'(prod_wx_q);
      sum_wy_q <= sum_wy_q + SUM_BITS'(prod_wy_q);
      sum_w_q  <= sum_w_q + SW_BITS'(prod_w_q);
    end
  end

  // Restoring divide step on magnitudes
  always_comb begin
    trial_x  = {rem_x_q, dvd_x_q[SUM_BITS-1]};
    trial_y  = {rem_y_q, dvd_y_q[SUM_BITS-1]};
    ge_x     = trial_x >= {1'b0, sum_w_q};
    ge_y     = trial_y >= {1'b0, sum_w_q};
    rem_x_nx = ge_x ? SW_BITS'(trial_x - {1'b0, sum_w_q}) : trial_x[SW_BITS-1:0];
    rem_y_nx = ge_y ? SW_BITS'(trial_y - {1'b0, sum_w_q}) : trial_y[SW_BITS-1:0];
    quo_x_nx = {quo_x_q[COORD_BITS-2:0], ge_x};
    quo_y_nx = {quo_y_q[COORD_BITS-2:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == S_SETUP) begin
      div_cnt_q <= '0;
    end else if (state_q == S_DIV) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SETUP) begin
      neg_x_q <= sum_wx_q[SUM_BITS-1];
      neg_y_q <= sum_wy_q[SUM_BITS-1];
      dvd_x_q <= sum_wx_q[SUM_BITS-1] ? SUM_BITS'(-sum_wx_q) : SUM_BITS'(sum_wx_q);
      dvd_y_q <= sum_wy_q[SUM_BITS-1] ? SUM_BITS'(-sum_wy_q) : SUM_BITS'(sum_wy_q);
      rem_x_q <= '0;
      rem_y_q <= '0;
      quo_x_q <= '0;
      quo_y_q <= '0;
    end else if (state_q == S_DIV) begin
      dvd_x_q <= dvd_x_q << 1;
      dvd_y_q <= dvd_y_q << 1;
      rem_x_q <= rem_x_nx;
      rem_y_q <= rem_y_nx;
      quo_x_q <= quo_x_nx;
      quo_y_q <= quo_y_nx;
    end
  end

  // Centroid, truncated toward zero
  always_ff @(posedge clk_i) begin
    if (state_q == S_SETUP) begin
      cok_q <= (sum_w_q != '0);
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (state_q == S_DIV && div_cnt_q == DIV_LAST) begin
      cx_q <= neg_x_q ? $signed(-quo_x_nx) : $signed(quo_x_nx);
      cy_q <= neg_y_q ? $signed(-quo_y_nx) : $signed(quo_y_nx);
    end
  end

  // Point memory: written while loading, read during the emit pass only
  assign rd_issue = (state_q == S_EMIT) && (rd_cnt_q < cnt_q) && !rd_pend_q &&
                    (!out_vld_q || res_o.ready);

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_q[cnt_q[IDX_BITS-1:0]] <= {pts_i.point_valid, pts_i.coord_x, pts_i.coord_y};
    end
    if (rd_issue) begin
      rdata_q <= mem_q[rd_cnt_q[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_issue;
      if (last_xfer) begin
        rd_cnt_q <= '0;
      end else if (rd_issue) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  // Recenter the read point into the output register
  assign rd_valid = rdata_q[MEM_W-1];
  assign rd_x     = $signed(rdata_q[2*COORD_BITS-1:COORD_BITS]);
  assign rd_y     = $signed(rdata_q[COORD_BITS-1:0]);
  assign rd_ok    = rd_valid && cok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rd_pend_q) begin
      out_vld_q <= 1'b1;
    end else if (out_xfer) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      pok_q   <= rd_ok;
      last_q  <= (rd_cnt_q == cnt_q);
      adj_x_q <= rd_ok ? (COORD_BITS+1)'(rd_x) - (COORD_BITS+1)'(cx_q) : '0;
      adj_y_q <= rd_ok ? (COORD_BITS+1)'(rd_y) - (COORD_BITS+1)'(cy_q) : '0;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.adj_x     = adj_x_q;
  assign res_o.adj_y     = adj_y_q;
  assign res_o.point_ok  = pok_q;
  assign res_o.center_x  = cx_q;
  assign res_o.center_y  = cy_q;
  assign res_o.center_ok = cok_q;
  assign res_o.last_out  = last_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("point count above capacity");

  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (state_q == S_EMIT))
    else $error("result valid outside the emit pass");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (sum_w_q != '0))
    else $error("divide running with zero weight sum");

  a_pass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_xfer |=> (cnt_q == '0) && (sum_w_q == '0) && (state_q == S_LOAD))
    else $error("state not cleared after the final result");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> !out_vld_q || res_o.ready)
    else $error("memory read issued with output register held");
`endif

endmodule
